>>> design/pws_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pws_pkg
// shared types, codes and helpers of the piecewise waveform sum unit
// ----------------------------------------------------------------------------
package pws_pkg;

   typedef enum logic [1:0] {
      ST_EVALUATED = 2'd0,
      ST_LOADED    = 2'd1,
      ST_UNDEFINED = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      KIND_CONST    = 2'd0,
      KIND_RAMP     = 2'd1,
      KIND_TRIANGLE = 2'd2,
      KIND_SINE     = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic [31:0]        start_time;
      logic [31:0]        end_time;
      logic signed [31:0] param_a;
      logic [31:0]        param_b;
      logic [15:0]        param_c;
   } slot_rec_type;

   localparam int REC_BITS = $bits(slot_rec_type);

   localparam logic [16:0] SIN_A    = 17'd102944;
   localparam logic [16:0] SIN_B    = 17'd42047;
   localparam logic [16:0] SIN_C    = 17'd4640;
   localparam logic [16:0] ONE_Q16  = 17'd65536;
   localparam logic [5:0]  DIV_LAST = 6'd63;

   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH, S_READ, S_CHECK,
      S_RAMP_MUL, S_RAMP_FIN,
      S_TRI_MUL, S_DIV_INIT, S_DIV, S_TRI_FIN,
      S_PH_MUL, S_FOLD, S_X2, S_MC, S_MB, S_MA, S_SAT, S_AMP, S_AMP_FIN,
      S_ACC, S_NEXT, S_RESULT
   } ctl_state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_CAPTURE, OP_WRITE, OP_READ, OP_MATCH,
      OP_MUL_RAMP, OP_RAMP_FIN,
      OP_MUL_TRI, OP_DIV_INIT, OP_DIV_STEP, OP_TRI_FIN,
      OP_MUL_PHASE, OP_FOLD, OP_MUL_XX, OP_MUL_C, OP_MUL_B, OP_MUL_A,
      OP_SINE_SAT, OP_MUL_AMP, OP_AMP_FIN,
      OP_ACC, OP_NEXT, OP_RESULT
   } dp_op_type;

   typedef struct packed {
      logic     is_eval;
      logic     hit;
      kind_type kind;
      logic     in_window;
      logic     tri_rise;
      logic     tri_fall;
      logic     div_last;
      logic     last_slot;
      logic     rsp_free;
   } dp_stat_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sd2147483647) r = 32'sh7fffffff;
      else if (v < -66'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

endpackage
`default_nettype wire

>>> design/pws_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pws_req_if
// request channel: load or evaluate word
// ----------------------------------------------------------------------------
interface pws_req_if;
   logic               valid;
   logic               ready;
   logic               op;
   logic [3:0]         slot;
   logic [7:0]         combo;
   logic [1:0]         kind;
   logic [31:0]        start_time;
   logic [31:0]        end_time;
   logic signed [31:0] param_a;
   logic [31:0]        param_b;
   logic [15:0]        param_c;
   logic [31:0]        eval_time;

   modport source(output valid, op, slot, combo, kind, start_time, end_time,
                  param_a, param_b, param_c, eval_time, input ready);
   modport sink(input valid, op, slot, combo, kind, start_time, end_time,
                param_a, param_b, param_c, eval_time, output ready);
endinterface
`default_nettype wire

>>> design/pws_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pws_rsp_if
// response channel: sum value and status word
// ----------------------------------------------------------------------------
interface pws_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [39:0] value;
   logic [1:0]         status;

   modport source(output valid, value, status, input ready);
   modport sink(input valid, value, status, output ready);
endinterface
`default_nettype wire

>>> design/pws_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pws_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module pws_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire                                    clock,
   input  wire                                    we,
   input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire [WIDTH-1:0]                        wdata,
   input  wire                                    re,
   input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      if (re) rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

>>> design/pws_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pws_ctrl
// sequencer: walks the slots and steps the shared datapath per component
// ----------------------------------------------------------------------------
module pws_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  pws_pkg::dp_stat_type stat,
   output pws_pkg::dp_op_type   op
);
   import pws_pkg::*;

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      op        = OP_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op       = OP_CAPTURE;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (stat.is_eval) state_in = S_READ;
            else begin
               op       = OP_WRITE;
               state_in = S_RESULT;
            end
         end
         S_READ: begin
            op       = OP_READ;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            op = OP_MATCH;
            if (!stat.hit) state_in = S_NEXT;
            else begin
               unique case (stat.kind)
                  KIND_CONST:    state_in = S_ACC;
                  KIND_RAMP:     state_in = stat.in_window ? S_RAMP_MUL : S_ACC;
                  KIND_TRIANGLE: state_in = (stat.tri_rise || stat.tri_fall) ?
                                            S_TRI_MUL : S_ACC;
                  KIND_SINE:     state_in = stat.in_window ? S_PH_MUL : S_ACC;
                  default:       state_in = S_ACC;
               endcase
            end
         end
         S_RAMP_MUL: begin op = OP_MUL_RAMP; state_in = S_RAMP_FIN; end
         S_RAMP_FIN: begin op = OP_RAMP_FIN; state_in = S_ACC; end
         S_TRI_MUL:  begin op = OP_MUL_TRI;  state_in = S_DIV_INIT; end
         S_DIV_INIT: begin op = OP_DIV_INIT; state_in = S_DIV; end
         S_DIV: begin
            op = OP_DIV_STEP;
            if (stat.div_last) state_in = S_TRI_FIN;
         end
         S_TRI_FIN:  begin op = OP_TRI_FIN;   state_in = S_ACC; end
         S_PH_MUL:   begin op = OP_MUL_PHASE; state_in = S_FOLD; end
         S_FOLD:     begin op = OP_FOLD;      state_in = S_X2; end
         S_X2:       begin op = OP_MUL_XX;    state_in = S_MC; end
         S_MC:       begin op = OP_MUL_C;     state_in = S_MB; end
         S_MB:       begin op = OP_MUL_B;     state_in = S_MA; end
         S_MA:       begin op = OP_MUL_A;     state_in = S_SAT; end
         S_SAT:      begin op = OP_SINE_SAT;  state_in = S_AMP; end
         S_AMP:      begin op = OP_MUL_AMP;   state_in = S_AMP_FIN; end
         S_AMP_FIN:  begin op = OP_AMP_FIN;   state_in = S_ACC; end
         S_ACC:      begin op = OP_ACC;       state_in = S_NEXT; end
         S_NEXT: begin
            op       = OP_NEXT;
            state_in = stat.last_slot ? S_RESULT : S_READ;
         end
         S_RESULT: begin
            if (stat.rsp_free) begin
               op       = OP_RESULT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule
`default_nettype wire

>>> design/pws_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pws_datapath
// slot store, shared multiplier, bit-serial divider, accumulator, output word
// ----------------------------------------------------------------------------
module pws_datapath #(
   parameter int SLOTS      = 16,
   parameter int LABEL_BITS = 8
) (
   input  wire                  clock,
   input  wire                  reset,
   pws_req_if.sink              req,
   pws_rsp_if.source            rsp,
   input  pws_pkg::dp_op_type   op,
   output pws_pkg::dp_stat_type stat
);
   import pws_pkg::*;

   localparam int IDX_BITS = SLOTS > 1 ? $clog2(SLOTS) : 1;
   localparam int RAM_W    = LABEL_BITS + REC_BITS;

   // request hold
   logic                  is_eval_ff, is_eval_in;
   logic [3:0]            slot_ff, slot_in;
   logic [LABEL_BITS-1:0] label_ff, label_in;
   slot_rec_type          wrec_ff, wrec_in;
   logic [31:0]           t_ff, t_in;

   // walk and sum
   logic [SLOTS-1:0]      valid_ff, valid_in;
   logic                  replaced_ff, replaced_in;
   logic [IDX_BITS-1:0]   idx_ff, idx_in;
   logic                  defined_ff, defined_in;
   logic signed [39:0]    sum_ff, sum_in;
   logic signed [31:0]    comp_ff, comp_in;

   // arithmetic
   logic signed [65:0]    prod_ff, prod_in;
   logic [31:0]           den_ff, den_in;
   logic [31:0]           rem_ff, rem_in;
   logic [63:0]           num_ff, num_in;
   logic [5:0]            cnt_ff, cnt_in;
   logic                  neg_ff, neg_in;
   logic [16:0]           x_ff, x_in;
   logic [16:0]           x2_ff, x2_in;
   logic [1:0]            quad_ff, quad_in;
   logic signed [17:0]    sin_ff, sin_in;

   // response word
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [39:0]    rsp_value_ff, rsp_value_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;

   logic                  ram_we, ram_re;
   logic [RAM_W-1:0]      ram_rdata;
   logic [8:0]            slot_ext;
   logic [15:0]           combo_ext;
   logic                  slot_ok;
   logic [LABEL_BITS-1:0] rd_label;
   slot_rec_type          rd;
   logic [31:0]           t_sub_st, en_sub_t, b_sub_st, en_sub_b;
   logic signed [32:0]    mul_a, mul_b;
   logic signed [65:0]    rnd_w;
   logic [15:0]           ang;
   logic [14:0]           fold_q;
   logic [32:0]           trial;
   logic [63:0]           mag;
   logic [16:0]           sin_mag;

   assign slot_ext  = {5'd0, slot_ff};
   assign combo_ext = {8'd0, req.combo};
   assign slot_ok   = slot_ext < 9'(SLOTS);
   assign rd_label  = ram_rdata[REC_BITS +: LABEL_BITS];
   assign rd        = slot_rec_type'(ram_rdata[REC_BITS-1:0]);
   assign t_sub_st  = t_ff - rd.start_time;
   assign en_sub_t  = rd.end_time - t_ff;
   assign b_sub_st  = rd.param_b - rd.start_time;
   assign en_sub_b  = rd.end_time - rd.param_b;
   assign rnd_w     = (prod_ff + 66'sd32768) >>> 16;
   assign ram_we    = (op == OP_WRITE) && slot_ok;
   assign ram_re    = (op == OP_READ);

   pws_ram #(.WIDTH(RAM_W), .DEPTH(SLOTS)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (slot_ext[IDX_BITS-1:0]),
      .wdata ({label_ff, wrec_ff}),
      .re    (ram_re),
      .raddr (idx_ff),
      .rdata (ram_rdata)
   );

   always_comb begin
      stat.is_eval   = is_eval_ff;
      stat.hit       = valid_ff[idx_ff] && (rd_label == label_ff);
      stat.kind      = rd.kind;
      stat.in_window = (rd.start_time < t_ff) && (t_ff <= rd.end_time);
      stat.tri_rise  = (rd.start_time < t_ff) && (t_ff <= rd.param_b);
      stat.tri_fall  = (rd.param_b < t_ff) && (t_ff <= rd.end_time);
      stat.div_last  = cnt_ff == DIV_LAST;
      stat.last_slot = idx_ff == IDX_BITS'(SLOTS - 1);
      stat.rsp_free  = !rsp_valid_ff || rsp.ready;
   end

   always_comb begin
      is_eval_in    = is_eval_ff;
      slot_in       = slot_ff;
      label_in      = label_ff;
      wrec_in       = wrec_ff;
      t_in          = t_ff;
      valid_in      = valid_ff;
      replaced_in   = replaced_ff;
      idx_in        = idx_ff;
      defined_in    = defined_ff;
      sum_in        = sum_ff;
      comp_in       = comp_ff;
      den_in        = den_ff;
      rem_in        = rem_ff;
      num_in        = num_ff;
      cnt_in        = cnt_ff;
      neg_in        = neg_ff;
      x_in          = x_ff;
      x2_in         = x2_ff;
      quad_in       = quad_ff;
      sin_in        = sin_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      mul_a         = '0;
      mul_b         = '0;
      ang           = rnd_w[15:0] + rd.param_c;
      fold_q        = ang[14] ? 15'(15'd16384 - {1'b0, ang[13:0]}) : {1'b0, ang[13:0]};
      trial         = {rem_ff, num_ff[63]};
      mag           = prod_ff[65] ? 64'(-prod_ff) : prod_ff[63:0];
      sin_mag       = (rnd_w[19:0] > 20'(ONE_Q16)) ? ONE_Q16 : rnd_w[16:0];

      case (op)
         OP_CAPTURE: begin
            is_eval_in         = req.op;
            slot_in            = req.slot;
            label_in           = combo_ext[LABEL_BITS-1:0];
            wrec_in.kind       = kind_type'(req.kind);
            wrec_in.start_time = req.start_time;
            wrec_in.end_time   = req.end_time;
            wrec_in.param_a    = req.param_a;
            wrec_in.param_b    = req.param_b;
            wrec_in.param_c    = req.param_c;
            t_in               = req.eval_time;
            idx_in             = '0;
            defined_in         = combo_ext[LABEL_BITS-1:0] == '0;
            if (combo_ext[LABEL_BITS-1:0] == '0 && !replaced_ff)
               sum_in = {8'd0, req.eval_time[31] ? 32'h7fffffff : req.eval_time};
            else
               sum_in = '0;
         end
         OP_WRITE: begin
            if (slot_ok) begin
               valid_in[slot_ext[IDX_BITS-1:0]] = 1'b1;
               if (label_ff == '0) replaced_in = 1'b1;
            end
         end
         OP_MATCH: begin
            defined_in = defined_ff || stat.hit;
            comp_in    = (rd.kind == KIND_CONST && stat.in_window) ? rd.param_a : '0;
         end
         OP_MUL_RAMP: begin
            mul_a = {1'b0, t_sub_st};
            mul_b = {rd.param_b[31], rd.param_b};
         end
         OP_RAMP_FIN: comp_in = sat32(rnd_w + 66'(rd.param_a));
         OP_MUL_TRI: begin
            mul_a  = {1'b0, stat.tri_rise ? t_sub_st : en_sub_t};
            mul_b  = 33'(rd.param_a);
            den_in = stat.tri_rise ? b_sub_st : en_sub_b;
         end
         OP_DIV_INIT: begin
            neg_in = prod_ff[65];
            num_in = mag + {33'd0, den_ff[31:1]};
            rem_in = '0;
            cnt_in = '0;
         end
         OP_DIV_STEP: begin
            if (trial >= {1'b0, den_ff}) begin
               rem_in = 32'(trial - {1'b0, den_ff});
               num_in = {num_ff[62:0], 1'b1};
            end else begin
               rem_in = trial[31:0];
               num_in = {num_ff[62:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
         end
         OP_TRI_FIN: begin
            if (neg_ff) comp_in = (num_ff > 64'h80000000) ? 32'sh80000000 : -num_ff[31:0];
            else comp_in = (num_ff > 64'h7fffffff) ? 32'sh7fffffff : num_ff[31:0];
         end
         OP_MUL_PHASE: begin
            mul_a = {1'b0, rd.param_b};
            mul_b = {1'b0, t_sub_st};
         end
         OP_FOLD: begin
            quad_in = ang[15:14];
            x_in    = {fold_q, 2'b00};
         end
         OP_MUL_XX: begin
            mul_a = {16'd0, x_ff};
            mul_b = {16'd0, x_ff};
         end
         OP_MUL_C: begin
            x2_in = rnd_w[16:0];
            mul_a = {16'd0, rnd_w[16:0]};
            mul_b = 33'(SIN_C);
         end
         OP_MUL_B: begin
            mul_a = {16'd0, x2_ff};
            mul_b = 33'(SIN_B) - {16'd0, rnd_w[16:0]};
         end
         OP_MUL_A: begin
            mul_a = {16'd0, x_ff};
            mul_b = 33'(SIN_A) - {16'd0, rnd_w[16:0]};
         end
         OP_SINE_SAT: sin_in = quad_ff[1] ? -{1'b0, sin_mag} : {1'b0, sin_mag};
         OP_MUL_AMP: begin
            mul_a = 33'(rd.param_a);
            mul_b = 33'(sin_ff);
         end
         OP_AMP_FIN: comp_in = sat32(rnd_w);
         OP_ACC:     sum_in  = sum_ff + 40'(comp_ff);
         OP_NEXT:    idx_in  = idx_ff + 1'b1;
         OP_RESULT: begin
            rsp_valid_in = 1'b1;
            if (!is_eval_ff) begin
               rsp_value_in  = '0;
               rsp_status_in = ST_LOADED;
            end else if (!defined_ff) begin
               rsp_value_in  = '0;
               rsp_status_in = ST_UNDEFINED;
            end else begin
               rsp_value_in  = sum_ff;
               rsp_status_in = ST_EVALUATED;
            end
         end
         default: ;
      endcase
      prod_in = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         replaced_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         replaced_ff  <= replaced_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      is_eval_ff    <= is_eval_in;
      slot_ff       <= slot_in;
      label_ff      <= label_in;
      wrec_ff       <= wrec_in;
      t_ff          <= t_in;
      idx_ff        <= idx_in;
      defined_ff    <= defined_in;
      sum_ff        <= sum_in;
      comp_ff       <= comp_in;
      prod_ff       <= prod_in;
      den_ff        <= den_in;
      rem_ff        <= rem_in;
      num_ff        <= num_in;
      cnt_ff        <= cnt_in;
      neg_ff        <= neg_in;
      x_ff          <= x_in;
      x2_ff         <= x2_in;
      quad_ff       <= quad_in;
      sin_ff        <= sin_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp.valid  = rsp_valid_ff;
   assign rsp.value  = rsp_value_ff;
   assign rsp.status = rsp_status_ff;
endmodule
`default_nettype wire

>>> design/piecewise_waveform_sum_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// piecewise_waveform_sum_unit
// sums constant, ramp, triangle and sine components of a combination at a time
//
//   channel  dir  handshake      word
//   req_ch   in   valid/ready    op, slot, combo, kind, window, params, time
//   rsp_ch   out  valid/ready    value (40b signed Q24.16), status
//
// load: the captured word is written to its slot, then a loaded response is registered
// evaluate: each slot is read and matched; a hit adds its constant, ramp,
//   sine or triangle term (triangle by the 64-step bit-serial divider)
// one word in flight; a new word is taken while the last response waits
// a stalled response holds the next finished word in the result state
// reset clears the slot valid bits, the default flag and the response valid
// ----------------------------------------------------------------------------
module piecewise_waveform_sum_unit #(
   parameter int SLOTS      = 16,
   parameter int LABEL_BITS = 8
) (
   input wire        clock,
   input wire        reset,
   pws_req_if.sink   req_ch,
   pws_rsp_if.source rsp_ch
);
   import pws_pkg::*;

   dp_op_type   op;
   dp_stat_type stat;

   pws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .op        (op)
   );

   pws_datapath #(.SLOTS(SLOTS), .LABEL_BITS(LABEL_BITS)) u_datapath (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .op    (op),
      .stat  (stat)
   );
endmodule
`default_nettype wire

>>> design/pws_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pws_checker
// port-level checks of the piecewise waveform sum unit
// ----------------------------------------------------------------------------
module pws_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_ready,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [39:0] rsp_value,
   input wire [1:0]  rsp_status
);
   import pws_pkg::*;

   // stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_status))
      else $error("response word changed under stall");

   // load acknowledgment carries zero
   a_load_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_LOADED |-> rsp_value == '0)
      else $error("load response with nonzero value");

   // undefined combination carries zero
   a_undef_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_UNDEFINED |-> rsp_value == '0)
      else $error("undefined combination with nonzero value");

   // one word at a time: busy right after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second word taken while busy");
endmodule

bind piecewise_waveform_sum_unit pws_checker u_pws_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_value  (rsp_ch.value),
   .rsp_status (rsp_ch.status)
);
`default_nettype wire
